[sv/refcounted_page_allocator_unit_defines.svh]
// Assertion macros used by the page allocator top level.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RPA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("page allocator assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RPA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("page allocator assertion failed");

`endif

[sv/rpa_pkg.sv]
// Shared types and codes of the page allocator.
`timescale 1ns / 1ps

package rpa_pkg;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_INCR  = 2'd2;
   localparam logic [1:0] OP_GET   = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOMEM    = 3'd1;
   localparam logic [2:0] ST_BADADDR  = 3'd2;
   localparam logic [2:0] ST_COUNT    = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;
   localparam logic [2:0] ST_IGNORED  = 3'd5;

   localparam logic [7:0] COUNT_MAX = 8'd255;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_READ_STACK,
      CTL_READ_COUNT,
      CTL_UPDATE
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic rd_stack;
      logic rd_count;
      logic update;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dp_status_type;

endpackage

[sv/refcounted_page_allocator_unit.sv]
// Top level of the reference-counted physical page allocator.
`timescale 1ns / 1ps
`include "refcounted_page_allocator_unit_defines.svh"

// Channel    Direction  Handshake              Payload
// req_       in         req_valid / req_ready  op, page_addr
// rsp_       out        rsp_valid / rsp_ready  status, alloc_addr, ref_count, page_released
// csr_       in         csr_wr_en              first_managed_page (csr_wr_data)
//
// Each request word passes through acceptance, a read of the free-stack
// top, a read of the count memory at the chosen page, and the update that
// writes both memories and loads the result register.
// The two memory reads run in series because an alloc picks its page from the
// stack top before it can look up that page's count.
// The next word is accepted while a result still waits; the update phase
// holds only while the result register is still occupied.
// The count memory needs no clearing pass: until the fresh pointer wraps, pages
// at or below it have never been issued and read as zero.
// Reset is synchronous and active high.

module refcounted_page_allocator_unit #(
   parameter int unsigned NUM_PAGES  = 32768,
   parameter int unsigned PAGE_SHIFT = 12,
   parameter logic [31:0] MEM_BASE   = 32'h8000_0000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_page_addr,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_alloc_addr,
   output logic [7:0]  rsp_ref_count,
   output logic        rsp_page_released
);

   // Command and status between the sequencer and the datapath.
   rpa_pkg::ctl_cmd_type   cmd;
   rpa_pkg::dp_status_type dp_status;

   // The sequencer owns the request handshake and orders the phases.
   rpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // The datapath holds both memories, the stack and fresh pointers, the
   // configuration register and the result register.
   rpa_datapath #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_SHIFT (PAGE_SHIFT),
      .MEM_BASE   (MEM_BASE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .dp_status         (dp_status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_op            (req_op),
      .req_page_addr     (req_page_addr),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_alloc_addr    (rsp_alloc_addr),
      .rsp_ref_count     (rsp_ref_count),
      .rsp_page_released (rsp_page_released)
   );

   // Only one phase runs in any cycle.
   `RPA_ASSERT_SAME(a_one_phase, clock, reset, 1'b1,
      $onehot0({cmd.load, cmd.rd_stack, cmd.rd_count, cmd.update}))

   // A word is processed alone: no second word enters right behind it.
   `RPA_ASSERT_NEXT(a_no_overlap, clock, reset, req_valid && req_ready, !req_ready)

   // The update always leaves a result waiting on the response side.
   `RPA_ASSERT_NEXT(a_update_result, clock, reset, cmd.update, rsp_valid)

   // A released page comes only from a successful free down to zero.
   `RPA_ASSERT_SAME(a_release_clean, clock, reset, rsp_valid && rsp_page_released,
      rsp_status == rpa_pkg::ST_OK && rsp_ref_count == 8'd0)

endmodule

[sv/rpa_ctrl.sv]
// Sequencer that steps each request word through read and update phases.
`timescale 1ns / 1ps

module rpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rpa_pkg::dp_status_type dp_status,
   output rpa_pkg::ctl_cmd_type   cmd
);

   rpa_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpa_pkg::CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         rpa_pkg::CTL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = rpa_pkg::CTL_READ_STACK;
            end
         end
         rpa_pkg::CTL_READ_STACK: begin
            cmd.rd_stack = 1'b1;
            state_in     = rpa_pkg::CTL_READ_COUNT;
         end
         rpa_pkg::CTL_READ_COUNT: begin
            cmd.rd_count = 1'b1;
            state_in     = rpa_pkg::CTL_UPDATE;
         end
         rpa_pkg::CTL_UPDATE: begin
            // Wait here while the previous result still sits unclaimed.
            if (!dp_status.out_busy) begin
               cmd.update = 1'b1;
               state_in   = rpa_pkg::CTL_IDLE;
            end
         end
         default: begin
            state_in = rpa_pkg::CTL_IDLE;
         end
      endcase
   end

endmodule

[sv/rpa_datapath.sv]
// Count and free-stack memories, pointers, request decode and result register.
`timescale 1ns / 1ps

module rpa_datapath #(
   parameter int unsigned NUM_PAGES  = 32768,
   parameter int unsigned PAGE_SHIFT = 12,
   parameter logic [31:0] MEM_BASE   = 32'h8000_0000
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rpa_pkg::ctl_cmd_type   cmd,
   output rpa_pkg::dp_status_type dp_status,
   input  logic                   csr_wr_en,
   input  logic [15:0]            csr_wr_data,
   input  logic [1:0]             req_op,
   input  logic [31:0]            req_page_addr,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_status,
   output logic [31:0]            rsp_alloc_addr,
   output logic [7:0]             rsp_ref_count,
   output logic                   rsp_page_released
);

   localparam int unsigned IDX_W = $clog2(NUM_PAGES);
   localparam int unsigned SP_W  = IDX_W + 1;
   localparam logic [63:0] BASE64    = 64'(MEM_BASE);
   localparam logic [63:0] TOP64     = BASE64 + (64'(NUM_PAGES) << PAGE_SHIFT);
   localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;
   localparam logic [IDX_W-1:0] FRESH_RESET = IDX_W'(NUM_PAGES - 1);
   localparam logic [SP_W-1:0]  SP_LIMIT    = SP_W'(NUM_PAGES);

   logic [7:0]       cnt_mem   [NUM_PAGES];
   logic [IDX_W-1:0] stack_mem [NUM_PAGES];

   logic [15:0]      first_ff;
   logic [1:0]       op_ff;
   logic [31:0]      addr_ff;
   logic [SP_W-1:0]  sp_ff;
   logic [IDX_W-1:0] fresh_ff;
   logic             wrapped_ff;
   logic [IDX_W-1:0] stack_top_ff;
   logic [IDX_W-1:0] sel_idx_ff;
   logic             touched_ff;
   logic [7:0]       cnt_rd_ff;

   logic             rsp_valid_ff;
   logic [2:0]       rsp_status_ff;
   logic [31:0]      rsp_addr_ff;
   logic [7:0]       rsp_cnt_ff;
   logic             rsp_rel_ff;

   logic [63:0]      addr64;
   logic [63:0]      offset;
   logic             in_range;
   logic             aligned;
   logic [IDX_W-1:0] dec_idx;
   logic             below_first;
   logic             stack_nonempty;
   logic [SP_W-1:0]  sp_dec;
   logic [IDX_W-1:0] sel_idx;
   logic             sel_touched;
   logic             have_fresh;
   logic [7:0]       cur_cnt;

   logic [2:0]       res_status;
   logic [31:0]      res_addr;
   logic [7:0]       res_cnt;
   logic             res_rel;
   logic             cnt_we;
   logic [7:0]       cnt_wdata;
   logic             do_pop;
   logic             do_push;
   logic             do_fresh;

   // Request decode from the latched address.
   assign addr64      = {32'd0, addr_ff};
   assign in_range    = (addr64 >= BASE64) && (addr64 < TOP64);
   assign offset      = addr64 - BASE64;
   assign aligned     = (addr64 & PAGE_MASK) == 64'd0;
   assign dec_idx     = IDX_W'(offset >> PAGE_SHIFT);
   assign below_first = 32'(dec_idx) < 32'(first_ff);

   assign stack_nonempty = sp_ff != '0;
   assign sp_dec         = sp_ff - SP_W'(1);
   assign have_fresh     = !wrapped_ff && (32'(fresh_ff) >= 32'(first_ff));

   // Until the fresh pointer wraps, pages at or below it have never been handed
   // out, so their count is zero whatever the memory holds.
   always_comb begin
      if (op_ff == rpa_pkg::OP_ALLOC) begin
         sel_idx     = stack_nonempty ? stack_top_ff : fresh_ff;
         sel_touched = stack_nonempty;
      end else begin
         sel_idx     = dec_idx;
         sel_touched = wrapped_ff || (dec_idx > fresh_ff);
      end
   end

   assign cur_cnt = touched_ff ? cnt_rd_ff : 8'd0;

   always_comb begin
      res_status = rpa_pkg::ST_OK;
      res_addr   = 32'd0;
      res_cnt    = 8'd0;
      res_rel    = 1'b0;
      cnt_we     = 1'b0;
      cnt_wdata  = 8'd0;
      do_pop     = 1'b0;
      do_push    = 1'b0;
      do_fresh   = 1'b0;
      case (op_ff)
         rpa_pkg::OP_ALLOC: begin
            if (!stack_nonempty && !have_fresh) begin
               res_status = rpa_pkg::ST_NOMEM;
            end else if (cur_cnt != 8'd0) begin
               res_status = rpa_pkg::ST_COUNT;
               res_cnt    = cur_cnt;
            end else begin
               do_pop    = stack_nonempty;
               do_fresh  = !stack_nonempty;
               cnt_we    = 1'b1;
               cnt_wdata = 8'd1;
               res_addr  = 32'(BASE64 + (64'(sel_idx_ff) << PAGE_SHIFT));
               res_cnt   = 8'd1;
            end
         end
         rpa_pkg::OP_FREE: begin
            if (!aligned || !in_range || below_first) begin
               res_status = rpa_pkg::ST_BADADDR;
            end else if (cur_cnt == 8'd0) begin
               res_status = rpa_pkg::ST_COUNT;
            end else begin
               cnt_we    = 1'b1;
               cnt_wdata = cur_cnt - 8'd1;
               res_cnt   = cur_cnt - 8'd1;
               if (cur_cnt == 8'd1) begin
                  res_rel = 1'b1;
                  do_push = sp_ff < SP_LIMIT;
               end
            end
         end
         rpa_pkg::OP_INCR: begin
            if (!in_range) begin
               res_status = rpa_pkg::ST_IGNORED;
            end else if (cur_cnt == 8'd0) begin
               res_status = rpa_pkg::ST_COUNT;
            end else if (cur_cnt == rpa_pkg::COUNT_MAX) begin
               res_status = rpa_pkg::ST_OVERFLOW;
               res_cnt    = rpa_pkg::COUNT_MAX;
            end else begin
               cnt_we    = 1'b1;
               cnt_wdata = cur_cnt + 8'd1;
               res_cnt   = cur_cnt + 8'd1;
            end
         end
         rpa_pkg::OP_GET: begin
            if (!in_range) begin
               res_status = rpa_pkg::ST_IGNORED;
            end else begin
               res_cnt = cur_cnt;
            end
         end
         default: begin
            res_status = rpa_pkg::ST_OK;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= 16'd0;
         sp_ff        <= '0;
         fresh_ff     <= FRESH_RESET;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            first_ff <= csr_wr_data;
         end
         if (cmd.update) begin
            rsp_valid_ff <= 1'b1;
            if (do_pop) begin
               sp_ff <= sp_dec;
            end else if (do_push) begin
               sp_ff <= sp_ff + SP_W'(1);
            end
            if (do_fresh) begin
               if (fresh_ff == '0) begin
                  wrapped_ff <= 1'b1;
               end else begin
                  fresh_ff <= fresh_ff - IDX_W'(1);
               end
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers and memories.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         addr_ff <= req_page_addr;
      end
      if (cmd.rd_stack) begin
         stack_top_ff <= stack_mem[sp_dec[IDX_W-1:0]];
      end
      if (cmd.rd_count) begin
         sel_idx_ff <= sel_idx;
         touched_ff <= sel_touched;
         cnt_rd_ff  <= cnt_mem[sel_idx];
      end
      if (cmd.update) begin
         rsp_status_ff <= res_status;
         rsp_addr_ff   <= res_addr;
         rsp_cnt_ff    <= res_cnt;
         rsp_rel_ff    <= res_rel;
         if (cnt_we) begin
            cnt_mem[sel_idx_ff] <= cnt_wdata;
         end
         if (do_push) begin
            stack_mem[sp_ff[IDX_W-1:0]] <= sel_idx_ff;
         end
      end
   end

   assign dp_status.out_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_alloc_addr    = rsp_addr_ff;
   assign rsp_ref_count     = rsp_cnt_ff;
   assign rsp_page_released = rsp_rel_ff;

endmodule
